[rtl/core/sle_pkg.sv]
// shared types, codes and key tables of the scancode line editor
`default_nettype none

package sle_pkg;

   // field widths of the streams
   localparam int OPCODE_W    = 2;
   localparam int CODE_W      = 8;
   localparam int INDEX_W     = 7;
   localparam int INDEX_COUNT = 2 ** INDEX_W;
   localparam int CHAR_W      = 8;
   localparam int LEN_W       = 7;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 32;

   // default line buffer depth
   localparam int LINE_DEPTH_DEFAULT = 128;

   // operation codes
   localparam logic [OPCODE_W-1:0] OP_SCAN  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_START = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_READ  = 2'd2;

   // set-1 key codes
   localparam logic [CODE_W-1:0] KEY_BACKSPACE  = 8'h0E;
   localparam logic [CODE_W-1:0] KEY_EXTENDED   = 8'hE0;
   localparam logic [CODE_W-1:0] KEY_LSHIFT     = 8'h2A;
   localparam logic [CODE_W-1:0] KEY_RSHIFT     = 8'h36;
   localparam logic [CODE_W-1:0] KEY_CAPS       = 8'h3A;
   localparam logic [CODE_W-1:0] KEY_ENTER      = 8'h1C;
   localparam logic [CODE_W-1:0] KEY_LCTRL      = 8'h1D;
   localparam logic [CODE_W-1:0] MAKE_LIMIT     = 8'h58;
   localparam logic [CODE_W-1:0] RELEASE_OFFSET = 8'h80;

   // key tables, indexed by make code
   localparam int MAP_COUNT = 89;
   localparam int MAP_W     = 7;

   localparam logic [CHAR_W-1:0] PLAIN_MAP [0:MAP_COUNT-1] = '{
      8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30,
      8'h2D, 8'h3D, 8'h00, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
      8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h00, 8'h00, 8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68,
      8'h6A, 8'h6B, 8'h6C, 8'h3B, 8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
      8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h1B, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00
   };

   localparam logic [CHAR_W-1:0] UPPER_MAP [0:MAP_COUNT-1] = '{
      8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A, 8'h28, 8'h29,
      8'h5F, 8'h2B, 8'h00, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
      8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h00, 8'h00, 8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48,
      8'h4A, 8'h4B, 8'h4C, 8'h3A, 8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
      8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h1B, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00
   };

   // result of one step, handed from the key controller to the pipeline
   typedef struct packed {
      logic              echo_valid;
      logic [CHAR_W-1:0] echo_char;
      logic              backspace_event;
      logic              line_done;
      logic [LEN_W-1:0]  line_length;
      logic              is_read;
   } step_result_type;

endpackage

`default_nettype wire

[rtl/core/sle_line_store.sv]
// line buffer memory: one write port, one registered read port
`default_nettype none

module sle_line_store #(
   parameter int LINE_DEPTH = sle_pkg::LINE_DEPTH_DEFAULT,
   parameter int ADDR_W     = $clog2(LINE_DEPTH)
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [ADDR_W-1:0]         wr_addr,
   input  wire logic [sle_pkg::CHAR_W-1:0] wr_data,
   input  wire logic                      rd_en,
   input  wire logic [ADDR_W-1:0]         rd_addr,
   output logic      [sle_pkg::CHAR_W-1:0] rd_data_ff
);

   logic [sle_pkg::CHAR_W-1:0] mem [0:LINE_DEPTH-1];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

[rtl/core/sle_key_ctrl.sv]
// key decoder: shift, caps and line state, buffer write and read requests
`default_nettype none

module sle_key_ctrl #(
   parameter int LINE_DEPTH = sle_pkg::LINE_DEPTH_DEFAULT,
   parameter int ADDR_W     = $clog2(LINE_DEPTH)
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        fire,
   input  wire logic [sle_pkg::OPCODE_W-1:0] opcode,
   input  wire logic [sle_pkg::CODE_W-1:0]   scan_byte,
   input  wire logic [sle_pkg::INDEX_W-1:0]  read_index,
   output sle_pkg::step_result_type         result,
   output logic                             wr_en,
   output logic      [ADDR_W-1:0]           wr_addr,
   output logic      [sle_pkg::CHAR_W-1:0]   wr_data,
   output logic                             rd_en,
   output logic      [ADDR_W-1:0]           rd_addr
);

   logic [ADDR_W-1:0] fill_ff, fill_in;
   logic              armed_ff, armed_in;
   logic              caps_ff, caps_in;
   logic              ext_ff, ext_in;
   logic              lshift_ff, lshift_in;
   logic              rshift_ff, rshift_in;

   logic [sle_pkg::CODE_W-1:0] release_key;
   logic [sle_pkg::MAP_W-1:0]  map_idx;
   logic [sle_pkg::CHAR_W-1:0] mapped_char;
   logic [ADDR_W-1:0]          index_map [0:sle_pkg::INDEX_COUNT-1];

   // read position modulo the buffer depth, folded at elaboration
   for (genvar i = 0; i < sle_pkg::INDEX_COUNT; i++) begin : g_index_map
      assign index_map[i] = ADDR_W'(i % LINE_DEPTH);
   end

   assign rd_addr     = index_map[read_index];
   assign release_key = scan_byte - sle_pkg::RELEASE_OFFSET;
   assign map_idx     = scan_byte[sle_pkg::MAP_W-1:0];
   assign mapped_char = (lshift_ff || rshift_ff || caps_ff) ?
                        sle_pkg::UPPER_MAP[map_idx] : sle_pkg::PLAIN_MAP[map_idx];

   // step logic for the transfer taken this cycle
   always_comb begin
      fill_in   = fill_ff;
      armed_in  = armed_ff;
      caps_in   = caps_ff;
      ext_in    = ext_ff;
      lshift_in = lshift_ff;
      rshift_in = rshift_ff;
      wr_en     = 1'b0;
      wr_addr   = fill_ff;
      wr_data   = '0;
      rd_en     = 1'b0;
      result    = '0;
      result.is_read = (opcode == sle_pkg::OP_READ);

      if (fire) begin
         unique case (opcode)
            sle_pkg::OP_START: begin
               armed_in = 1'b1;
               fill_in  = '0;
            end
            sle_pkg::OP_READ: begin
               rd_en = 1'b1;
            end
            sle_pkg::OP_SCAN: begin
               priority if (scan_byte == sle_pkg::KEY_BACKSPACE) begin
                  result.backspace_event = 1'b1;
                  if (fill_ff != '0) begin
                     fill_in = fill_ff - 1'b1;
                     wr_en   = 1'b1;
                     wr_addr = fill_ff - 1'b1;
                  end
               end else if (scan_byte == sle_pkg::KEY_EXTENDED) begin
                  ext_in = 1'b1;
               end else if (ext_ff) begin
                  // byte after the extended prefix is dropped
                  ext_in = 1'b0;
               end else if (scan_byte > sle_pkg::MAKE_LIMIT) begin
                  // release: only the shift keys matter
                  if (release_key == sle_pkg::KEY_LSHIFT) begin
                     lshift_in = 1'b0;
                  end else if (release_key == sle_pkg::KEY_RSHIFT) begin
                     rshift_in = 1'b0;
                  end
               end else begin
                  if (scan_byte == sle_pkg::KEY_LSHIFT) begin
                     lshift_in = 1'b1;
                  end else if (scan_byte == sle_pkg::KEY_RSHIFT) begin
                     rshift_in = 1'b1;
                  end
                  if (armed_ff) begin
                     priority if (scan_byte == sle_pkg::KEY_LSHIFT ||
                                  scan_byte == sle_pkg::KEY_RSHIFT ||
                                  scan_byte == sle_pkg::KEY_LCTRL) begin
                        // modifiers only
                     end else if (scan_byte == sle_pkg::KEY_CAPS) begin
                        caps_in = ~caps_ff;
                     end else if (scan_byte == sle_pkg::KEY_ENTER) begin
                        wr_en            = 1'b1;
                        armed_in         = 1'b0;
                        result.line_done = 1'b1;
                     end else begin
                        result.echo_valid = 1'b1;
                        result.echo_char  = mapped_char;
                        if (fill_ff < ADDR_W'(LINE_DEPTH - 1)) begin
                           wr_en   = 1'b1;
                           wr_data = mapped_char;
                           fill_in = fill_ff + 1'b1;
                        end
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
      result.line_length = sle_pkg::LEN_W'(fill_in);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         armed_ff  <= 1'b0;
         caps_ff   <= 1'b0;
         ext_ff    <= 1'b0;
         lshift_ff <= 1'b0;
         rshift_ff <= 1'b0;
      end else begin
         fill_ff   <= fill_in;
         armed_ff  <= armed_in;
         caps_ff   <= caps_in;
         ext_ff    <= ext_in;
         lshift_ff <= lshift_in;
         rshift_ff <= rshift_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/scancode_line_editor_core.sv]
// top level of the scancode line editor: decoder, line buffer and result pipeline
//
//  channel   dir  handshake             payload
//  req_      in   req_tvalid/tready     tuser opcode, tdata scan_byte, read_index
//  rsp_      out  rsp_tvalid/tready     tdata echo, backspace, done, length, read data
//
// one transfer per cycle is taken while the output does not stall; a result
// passes the request stage, which waits on the registered read port of the
// line buffer memory, then the output register; the two part the two sides,
// so one request is still taken while a result waits to be taken
// reset clears the key and line state at once; the buffer itself needs no clearing
`default_nettype none

module scancode_line_editor_core #(
   parameter int LINE_DEPTH = sle_pkg::LINE_DEPTH_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // [1:0] opcode
   input  wire logic [sle_pkg::OPCODE_W-1:0]   req_tuser,
   // [7:0] scan_byte, [14:8] read_index, [15] zero
   input  wire logic [sle_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // [0] echo_valid, [8:1] echo_char, [9] backspace_event, [10] line_done,
   // [17:11] line_length, [25:18] read_data, [31:26] zero
   output logic      [sle_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam int ADDR_W = $clog2(LINE_DEPTH);

   logic                       fire;
   logic                       p1_move;
   sle_pkg::step_result_type   step_result;
   logic                       wr_en, rd_en;
   logic [ADDR_W-1:0]          wr_addr, rd_addr;
   logic [sle_pkg::CHAR_W-1:0] wr_data, rd_data;
   logic [sle_pkg::CHAR_W-1:0] read_char;

   logic                            p1_valid_ff, p1_valid_in;
   sle_pkg::step_result_type        p1_result_ff;
   logic                            out_valid_ff, out_valid_in;
   logic [sle_pkg::RSP_DATA_W-1:0]  out_data_ff;

   // handshake
   assign p1_move    = !out_valid_ff || rsp_tready;
   assign req_tready = !p1_valid_ff || p1_move;
   assign fire       = req_tvalid && req_tready;

   sle_key_ctrl #(
      .LINE_DEPTH (LINE_DEPTH),
      .ADDR_W     (ADDR_W)
   ) u_key_ctrl (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .opcode     (req_tuser),
      .scan_byte  (req_tdata[7:0]),
      .read_index (req_tdata[14:8]),
      .result     (step_result),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr)
   );

   sle_line_store #(
      .LINE_DEPTH (LINE_DEPTH),
      .ADDR_W     (ADDR_W)
   ) u_line_store (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   // stage valid bits
   always_comb begin
      p1_valid_in  = p1_valid_ff;
      out_valid_in = out_valid_ff;
      if (fire) begin
         p1_valid_in = 1'b1;
      end else if (p1_move) begin
         p1_valid_in = 1'b0;
      end
      if (p1_valid_ff && p1_move) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff  <= p1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload: request stage waits on the buffer read, then the output register
   assign read_char = p1_result_ff.is_read ? rd_data : '0;

   always_ff @(posedge clock) begin
      if (fire) begin
         p1_result_ff <= step_result;
      end
      if (p1_valid_ff && p1_move) begin
         out_data_ff <= {6'b0, read_char, p1_result_ff.line_length, p1_result_ff.line_done,
                         p1_result_ff.backspace_event, p1_result_ff.echo_char,
                         p1_result_ff.echo_valid};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

`default_nettype wire

[rtl/core/sle_checker.sv]
// port checker of the scancode line editor and its bind
`default_nettype none

module sle_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata
);

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // no result straight out of reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // an echo excludes backspace, line end and read data
   a_echo_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> !rsp_tdata[9] && !rsp_tdata[10] && rsp_tdata[25:18] == 8'h00)
      else $error("echo mixed with another event");

   // a character appears only with its echo flag
   a_char_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[8:1] != 8'h00 |-> rsp_tdata[0])
      else $error("echo character without echo flag");

   // with the output full and stalled, at most one more request is taken
   a_stall_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready && req_tvalid && req_tready && !$past(reset) ##1
      !rsp_tready |-> !req_tready)
      else $error("request taken beyond buffer capacity");

endmodule

bind scancode_line_editor_core sle_checker u_sle_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

[tb/line_editor_checker.sv]
// stream monitor for the scancode line editor: predicts every response and compares it
`default_nettype none

module line_editor_checker #(
   parameter int LINE_DEPTH = sle_pkg::LINE_DEPTH_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   input  wire logic                           req_tready,
   // [1:0] opcode
   input  wire logic [sle_pkg::OPCODE_W-1:0]   req_tuser,
   // [7:0] scan_byte, [14:8] read_index, [15] zero
   input  wire logic [sle_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic                           rsp_tvalid,
   input  wire logic                           rsp_tready,
   // [0] echo_valid, [8:1] echo_char, [9] backspace_event, [10] line_done,
   // [17:11] line_length, [25:18] read_data, [31:26] zero
   input  wire logic [sle_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output int                                  fail_count,
   output int                                  results_pending,
   output logic [LINE_DEPTH-1:0]               slot_written
);
   timeunit 1ns;
   timeprecision 1ps;

   import sle_pkg::*;

   // one response, laid out as on the response bus, listed from the top bit down
   typedef struct packed {
      logic [CHAR_W-1:0] read_data;
      logic [LEN_W-1:0]  line_length;
      logic              line_done;
      logic              backspace_event;
      logic [CHAR_W-1:0] echo_char;
      logic              echo_valid;
   } line_result_type;

   localparam int RESULT_W = $bits(line_result_type);
   localparam int KEY_COUNT = 89;

   // set-1 make code to character, no shift
   localparam logic [7:0] PLAIN_KEYS [0:KEY_COUNT-1] = '{
      8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30,
      8'h2D, 8'h3D, 8'h00, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
      8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h00, 8'h00, 8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68,
      8'h6A, 8'h6B, 8'h6C, 8'h3B, 8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
      8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h1B, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00
   };

   // set-1 make code to character, shift or caps lock
   localparam logic [7:0] UPPER_KEYS [0:KEY_COUNT-1] = '{
      8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A, 8'h28, 8'h29,
      8'h5F, 8'h2B, 8'h00, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
      8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h00, 8'h00, 8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48,
      8'h4A, 8'h4B, 8'h4C, 8'h3A, 8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
      8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h1B, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00
   };

   // shadow of the editor state
   logic [CHAR_W-1:0] line_chars [0:LINE_DEPTH-1];
   logic [LEN_W-1:0]  char_count;
   logic              entry_on;
   logic              caps_flag;
   logic              prefix_seen;
   logic              left_shift;
   logic              right_shift;

   line_result_type expected_results [$];

   task automatic store_char(input int pos, input logic [CHAR_W-1:0] ch);
      if (pos < LINE_DEPTH) begin
         line_chars[pos]   = ch;
         slot_written[pos] = 1'b1;
      end
   endtask

   // advance the shadow state by one request and build its response
   task automatic predict_step(
      input  logic [OPCODE_W-1:0] op,
      input  logic [CODE_W-1:0]   code,
      input  logic [INDEX_W-1:0]  idx,
      output line_result_type     res
   );
      logic [CODE_W-1:0] key;
      logic [CHAR_W-1:0] ch;
      res = '0;
      case (op)
         OP_START: begin
            entry_on   = 1'b1;
            char_count = '0;
         end
         OP_READ: begin
            res.read_data = line_chars[int'(idx) % LINE_DEPTH];
         end
         OP_SCAN: begin
            if (code == KEY_BACKSPACE) begin
               // handled even behind an extended prefix
               if (char_count != 0) begin
                  char_count = char_count - 1'b1;
                  store_char(int'(char_count), 8'h00);
               end
               res.backspace_event = 1'b1;
            end else if (code == KEY_EXTENDED) begin
               prefix_seen = 1'b1;
            end else if (prefix_seen) begin
               // byte after the prefix is dropped
               prefix_seen = 1'b0;
            end else if (code > MAKE_LIMIT) begin
               // break code, only the shift keys matter
               key = code - RELEASE_OFFSET;
               if (key == KEY_LSHIFT) begin
                  left_shift = 1'b0;
               end else if (key == KEY_RSHIFT) begin
                  right_shift = 1'b0;
               end
            end else begin
               if (code == KEY_LSHIFT) begin
                  left_shift = 1'b1;
               end else if (code == KEY_RSHIFT) begin
                  right_shift = 1'b1;
               end
               if (entry_on) begin
                  case (code)
                     // modifiers only move the shift flags
                     KEY_LSHIFT, KEY_RSHIFT, KEY_LCTRL: ;
                     KEY_CAPS: begin
                        caps_flag = ~caps_flag;
                     end
                     KEY_ENTER: begin
                        store_char(int'(char_count), 8'h00);
                        entry_on      = 1'b0;
                        res.line_done = 1'b1;
                     end
                     default: begin
                        ch = (left_shift || right_shift || caps_flag) ?
                             UPPER_KEYS[code[MAP_W-1:0]] : PLAIN_KEYS[code[MAP_W-1:0]];
                        res.echo_valid = 1'b1;
                        res.echo_char  = ch;
                        if (int'(char_count) < LINE_DEPTH - 1) begin
                           store_char(int'(char_count), ch);
                           char_count = char_count + 1'b1;
                        end
                     end
                  endcase
               end
            end
         end
         // unused opcode leaves the state alone
         default: ;
      endcase
      res.line_length = char_count;
   endtask

   task automatic check_field(input string name, input int want_v, input int got_v);
      if (want_v != got_v) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
         fail_count++;
      end
   endtask

   // compare responses, then predict the request taken at this edge
   always @(posedge clock) begin : monitor_step
      line_result_type got_r;
      line_result_type want_r;
      if (reset) begin
         char_count   = '0;
         entry_on     = 1'b0;
         caps_flag    = 1'b0;
         prefix_seen  = 1'b0;
         left_shift   = 1'b0;
         right_shift  = 1'b0;
         slot_written = '0;
         fail_count   = 0;
         expected_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_r = rsp_tdata[RESULT_W-1:0];
            if (expected_results.size() == 0) begin
               $display("%0t: response with none outstanding, expected none, actual %h",
                        $time, rsp_tdata);
               fail_count++;
            end else begin
               want_r = expected_results.pop_front();
               check_field("echo_valid", want_r.echo_valid, got_r.echo_valid);
               check_field("echo_char", want_r.echo_char, got_r.echo_char);
               check_field("backspace_event", want_r.backspace_event, got_r.backspace_event);
               check_field("line_done", want_r.line_done, got_r.line_done);
               check_field("line_length", want_r.line_length, got_r.line_length);
               check_field("read_data", want_r.read_data, got_r.read_data);
            end
         end
         if (req_tvalid && req_tready) begin
            predict_step(req_tuser, req_tdata[CODE_W-1:0],
                         req_tdata[CODE_W +: INDEX_W], want_r);
            expected_results.push_back(want_r);
         end
      end
      results_pending = expected_results.size();
   end

endmodule

`default_nettype wire

[tb/scancode_line_editor_core_tb.sv]
// top of the scancode line editor testbench: clock, reset, stimulus and verdict
`default_nettype none

module scancode_line_editor_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sle_pkg::*;

   localparam int CLOCK_HIGH      = 5;
   localparam int CLOCK_LOW       = 5;
   localparam int RESET_CYCLES    = 7;
   localparam int IDLE_LIMIT      = 5000;
   localparam int LONG_STALL      = 300;
   localparam int SETTLE_CYCLES   = 10;
   localparam int ITEMS_PER_PHASE = 290;

   // opcode with no operation behind it
   localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

   // a few plain keys and the edges of the code space
   localparam logic [CODE_W-1:0] KEY_NUL     = 8'h00;
   localparam logic [CODE_W-1:0] KEY_ONE     = 8'h02;
   localparam logic [CODE_W-1:0] KEY_Q       = 8'h10;
   localparam logic [CODE_W-1:0] KEY_P       = 8'h19;
   localparam logic [CODE_W-1:0] KEY_A       = 8'h1E;
   localparam logic [CODE_W-1:0] FIRST_WRAP  = MAKE_LIMIT + 8'h01;
   localparam logic [CODE_W-1:0] LAST_CODE   = 8'hFF;
   localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(INDEX_COUNT - 1);

   logic                    clock;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [OPCODE_W-1:0]     req_tuser  = '0;
   logic [REQ_DATA_W-1:0]   req_tdata  = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;

   int                      fail_count;
   int                      results_pending;
   logic [INDEX_COUNT-1:0]  slot_written;

   int send_idle_pct  = 0;
   int recv_idle_pct  = 0;
   int items_sent     = 0;
   int stall_requests = 0;
   int stall_served   = 0;
   int stall_left     = 0;
   int quiet_cycles   = 0;

   scancode_line_editor_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   line_editor_checker line_monitor (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tuser       (req_tuser),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .fail_count      (fail_count),
      .results_pending (results_pending),
      .slot_written    (slot_written)
   );

   // clock
   always begin
      clock = 1'b0;
      #(CLOCK_LOW);
      clock = 1'b1;
      #(CLOCK_HIGH);
   end

   // response side backpressure, with an occasional long hold-off
   always @(negedge clock) begin
      if (stall_requests != stall_served) begin
         stall_served = stall_requests;
         stall_left   = LONG_STALL;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
   end

   // watchdog on cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("FAIL scancode_line_editor_core");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // offer one request, with random gaps, and wait for its transfer
   task automatic send_request(
      input logic [OPCODE_W-1:0] op,
      input logic [CODE_W-1:0]   code,
      input logic [INDEX_W-1:0]  idx
   );
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {1'b0, idx, code};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_scan(input logic [CODE_W-1:0] code);
      send_request(OP_SCAN, code, INDEX_W'($urandom));
   endtask

   task automatic send_start();
      send_request(OP_START, CODE_W'($urandom), INDEX_W'($urandom));
   endtask

   // sender stops until every response is back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (results_pending != 0) @(negedge clock);
      @(negedge clock);
   endtask

   // random buffer slot that holds a character, -1 when there is none
   function automatic int pick_written_index();
      int start;
      int pos;
      start = $urandom_range(INDEX_COUNT - 1, 0);
      for (int i = 0; i < INDEX_COUNT; i++) begin
         pos = (start + i) % INDEX_COUNT;
         if (slot_written[pos]) return pos;
      end
      return -1;
   endfunction

   task automatic send_read();
      int idx;
      idx = pick_written_index();
      if (idx >= 0) send_request(OP_READ, CODE_W'($urandom), INDEX_W'(idx));
   endtask

   // one keystroke of a typed line
   task automatic type_key();
      int pick;
      pick = $urandom_range(99, 0);
      if (pick < 55) begin
         send_scan(CODE_W'($urandom_range(MAKE_LIMIT, 0)));
      end else if (pick < 63) begin
         send_scan($urandom_range(1, 0) ? KEY_LSHIFT : KEY_RSHIFT);
      end else if (pick < 71) begin
         send_scan(($urandom_range(1, 0) ? KEY_LSHIFT : KEY_RSHIFT) + RELEASE_OFFSET);
      end else if (pick < 76) begin
         send_scan(KEY_CAPS);
      end else if (pick < 84) begin
         send_scan(KEY_BACKSPACE);
      end else if (pick < 89) begin
         send_scan(KEY_EXTENDED);
         send_scan(CODE_W'($urandom));
      end else if (pick < 94) begin
         send_scan(CODE_W'($urandom_range(LAST_CODE, FIRST_WRAP)));
      end else begin
         send_scan(KEY_LCTRL);
      end
   endtask

   // any opcode with any fields, reads kept on written slots
   task automatic send_noise();
      logic [OPCODE_W-1:0] op;
      int                  idx;
      op  = OPCODE_W'($urandom);
      idx = $urandom_range(INDEX_COUNT - 1, 0);
      if (op == OP_READ) begin
         idx = pick_written_index();
         if (idx < 0) begin
            op  = OP_UNUSED;
            idx = 0;
         end
      end
      send_request(op, CODE_W'($urandom), INDEX_W'(idx));
   endtask

   // mostly whole lines: start, keys, enter, read back
   task automatic random_sequence();
      int pick;
      pick = $urandom_range(99, 0);
      if (pick < 65) begin
         send_start();
         repeat ($urandom_range(24, 1)) type_key();
         if ($urandom_range(99, 0) < 90) send_scan(KEY_ENTER);
         repeat ($urandom_range(4, 1)) send_read();
      end else if (pick < 80) begin
         repeat ($urandom_range(3, 1)) send_read();
      end else begin
         repeat ($urandom_range(3, 1)) send_noise();
      end
   endtask

   // type past the end of the buffer, then read its last and first slots
   task automatic fill_whole_line();
      send_start();
      repeat (INDEX_COUNT + 4) send_scan(CODE_W'($urandom_range(KEY_P, KEY_Q)));
      send_scan(KEY_BACKSPACE);
      send_scan(KEY_A);
      send_scan(KEY_A);
      send_scan(KEY_ENTER);
      send_request(OP_READ, CODE_W'($urandom), LAST_INDEX);
      send_request(OP_READ, CODE_W'($urandom), '0);
   endtask

   task automatic run_directed();
      // keys before any line entry is armed
      send_scan(KEY_BACKSPACE);
      send_scan(KEY_A);
      send_scan(KEY_LSHIFT);
      send_scan(KEY_LSHIFT + RELEASE_OFFSET);
      // armed: table edges, shift, caps, control
      send_start();
      send_scan(KEY_NUL);
      send_scan(MAKE_LIMIT);
      send_scan(KEY_Q);
      send_scan(KEY_RSHIFT);
      send_scan(KEY_ONE);
      send_scan(KEY_RSHIFT + RELEASE_OFFSET);
      send_scan(KEY_CAPS);
      send_scan(KEY_A);
      send_scan(KEY_CAPS);
      send_scan(KEY_LCTRL);
      // backspace behind an extended prefix, then the dropped byte
      send_scan(KEY_EXTENDED);
      send_scan(KEY_BACKSPACE);
      send_scan(KEY_A);
      // codes above the make range: the first, whose break key wraps, and the last
      send_scan(FIRST_WRAP);
      send_scan(LAST_CODE);
      // restart while armed, end the line, keys after enter
      send_start();
      send_scan(KEY_A);
      send_scan(KEY_ENTER);
      send_scan(KEY_A);
      send_request(OP_READ, KEY_NUL, '0);
      send_request(OP_READ, LAST_CODE, INDEX_W'(1));
      send_request(OP_UNUSED, LAST_CODE, LAST_INDEX);
   endtask

   initial begin : stimulus
      int  phase_base;
      bit  paused;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 20;
      recv_idle_pct = 53;
      run_directed();
      drain_results();

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 20;
               recv_idle_pct = 53;
            end
            1: begin
               send_idle_pct = 53;
               recv_idle_pct = 20;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         phase_base = items_sent;
         paused     = 1'b0;
         if (phase == 0) fill_whole_line();
         // long response hold-off while requests keep coming
         if (phase == 0) stall_requests++;
         while (items_sent - phase_base < ITEMS_PER_PHASE) begin
            if (!paused && items_sent - phase_base > ITEMS_PER_PHASE / 2) begin
               drain_results();
               paused = 1'b1;
            end
            random_sequence();
         end
         drain_results();
      end

      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0 && results_pending == 0) begin
         $display("PASS scancode_line_editor_core");
      end else begin
         $display("FAIL scancode_line_editor_core");
      end
      $finish;
   end

endmodule

`default_nettype wire
